### hw/rtl/bank_mapper_with_scanline_irq_top_defines.svh
// ----------------------------------------------------------------------------
// bank mapper assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BANK_MAPPER_WITH_SCANLINE_IRQ_TOP_DEFINES_SVH
`define BANK_MAPPER_WITH_SCANLINE_IRQ_TOP_DEFINES_SVH

// property checked at every clock edge outside reset
`define BMSI_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bmsi assertion failed");

// property checked at every clock edge, reset included
`define BMSI_ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bmsi assertion failed");

`endif

### hw/rtl/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// types and constants of the bank mapper with scanline interrupt
// ----------------------------------------------------------------------------
package bmsi_pkg;

    typedef enum logic [1:0] {
        ACT_REG_WRITE = 2'd0,
        ACT_CPU_READ  = 2'd1,
        ACT_PPU_ACC   = 2'd2,
        ACT_CPU_TICK  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_PRG_MASK    = 2'd0,
        CFG_CHR_MASK    = 2'd1,
        CFG_FALL_EDGE   = 2'd2,
        CFG_FILTER_TICK = 2'd3
    } cfg_index_t;

    // register window select, cpu address bits 14..13
    typedef enum logic [1:0] {
        WIN_BANK   = 2'd0,
        WIN_MIRROR = 2'd1,
        WIN_IRQ    = 2'd2,
        WIN_ENABLE = 2'd3
    } reg_win_t;

    localparam int InTdataW  = 40;
    localparam int OutTdataW = 24;

    localparam logic [7:0] PrgMaskReset   = 8'd63;
    localparam logic [7:0] ChrMaskReset   = 8'd255;
    localparam logic [7:0] FilterReset    = 8'd3;
    localparam logic [7:0] LowTicksMax    = 8'd255;
    localparam logic [7:0] PairMask       = 8'hFE;

    typedef struct packed {
        action_t     action;
        logic [15:0] address;
        logic [7:0]  data;
        logic [13:0] ppu_address;
    } item_t;

    typedef struct packed {
        logic [7:0] prg_bank;
        logic       prg_mapped;
        logic [7:0] chr_bank;
        logic       irq_line;
        logic       mirror_horizontal;
    } result_t;

endpackage

### hw/rtl/bmsi_in_stage.sv
// ----------------------------------------------------------------------------
// bmsi_in_stage
// input register of the request stream
// ----------------------------------------------------------------------------
module bmsi_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bmsi_pkg::item_t in_item,
    output logic            item_valid,
    output bmsi_pkg::item_t item,
    input  logic            advance
);

    logic            valid_reg;
    logic            valid_next;
    bmsi_pkg::item_t item_reg;

    // slot frees when empty or when its request moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/bmsi_core.sv
// ----------------------------------------------------------------------------
// bmsi_core
// mapper state, bank translation and scanline counter
// ----------------------------------------------------------------------------
module bmsi_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              step,
    input  bmsi_pkg::item_t   item,
    output bmsi_pkg::result_t result
);

    // configuration
    logic [7:0] prg_mask_reg;
    logic [7:0] chr_mask_reg;
    logic       fall_edge_reg;
    logic [7:0] filter_reg;

    // mapper state
    logic [7:0] bank_regs_reg [8];
    logic [7:0] bank_select_reg, bank_select_next;
    logic       mirror_reg, mirror_next;
    logic [7:0] latch_reg, latch_next;
    logic       reload_reg, reload_next;
    logic [7:0] counter_reg, counter_next;
    logic       irq_en_reg, irq_en_next;
    logic       irq_level_reg, irq_level_next;
    logic       a12_last_reg, a12_last_next;
    logic [7:0] low_ticks_reg, low_ticks_next;

    logic       bank_we;
    logic       a12;
    logic       odd;
    logic       edge_seen;
    logic [7:0] counter_new;
    logic [7:0] second_last;
    logic [7:0] prg_value;
    logic [2:0] chr_slot;
    logic [7:0] chr_value;
    logic [2:0] chr_index;

    assign a12 = item.ppu_address[12];
    assign odd = item.address[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mask_reg  <= bmsi_pkg::PrgMaskReset;
            chr_mask_reg  <= bmsi_pkg::ChrMaskReset;
            fall_edge_reg <= 1'b0;
            filter_reg    <= bmsi_pkg::FilterReset;
        end
        else if (cfg_we)
        begin
            case (bmsi_pkg::cfg_index_t'(cfg_index))
                bmsi_pkg::CFG_PRG_MASK:    prg_mask_reg  <= cfg_data;
                bmsi_pkg::CFG_CHR_MASK:    chr_mask_reg  <= cfg_data;
                bmsi_pkg::CFG_FALL_EDGE:   fall_edge_reg <= cfg_data[0];
                bmsi_pkg::CFG_FILTER_TICK: filter_reg    <= cfg_data;
                default:                   filter_reg    <= filter_reg;
            endcase
        end
    end

    // program bank lookup
    assign second_last = (prg_mask_reg - 8'd1) & prg_mask_reg;

    always_comb
    begin
        case (item.address[14:13])
            2'd0:    prg_value = bank_select_reg[6] ? second_last
                                                    : (bank_regs_reg[6] & prg_mask_reg);
            2'd1:    prg_value = bank_regs_reg[7] & prg_mask_reg;
            2'd2:    prg_value = bank_select_reg[6] ? (bank_regs_reg[6] & prg_mask_reg)
                                                    : second_last;
            default: prg_value = prg_mask_reg;
        endcase
    end

    // character bank lookup, 2k pairs in the lower half of the slot space
    assign chr_slot  = item.ppu_address[12:10] ^ {bank_select_reg[7], 2'b00};
    assign chr_index = chr_slot[2] ? (3'd2 + {1'b0, chr_slot[1:0]}) : {2'b00, chr_slot[1]};

    always_comb
    begin
        if (!chr_slot[2])
        begin
            chr_value = (bank_regs_reg[chr_index] & bmsi_pkg::PairMask)
                      | {7'd0, chr_slot[0]};
        end
        else
        begin
            chr_value = bank_regs_reg[chr_index];
        end
    end

    assign edge_seen = fall_edge_reg ? (a12_last_reg && !a12) : (!a12_last_reg && a12);

    always_comb
    begin
        bank_we          = 1'b0;
        bank_select_next = bank_select_reg;
        mirror_next      = mirror_reg;
        latch_next       = latch_reg;
        reload_next      = reload_reg;
        counter_next     = counter_reg;
        irq_en_next      = irq_en_reg;
        irq_level_next   = irq_level_reg;
        a12_last_next    = a12_last_reg;
        low_ticks_next   = low_ticks_reg;
        counter_new      = counter_reg - 8'd1;
        if (reload_reg || counter_reg == 8'd0)
        begin
            counter_new = latch_reg;
        end
        result = '0;

        case (item.action)
            bmsi_pkg::ACT_REG_WRITE:
            begin
                if (item.address[15])
                begin
                    case (bmsi_pkg::reg_win_t'(item.address[14:13]))
                        bmsi_pkg::WIN_BANK:
                        begin
                            if (odd)
                            begin
                                bank_we = 1'b1;
                            end
                            else
                            begin
                                bank_select_next = item.data;
                            end
                        end
                        bmsi_pkg::WIN_MIRROR:
                        begin
                            if (!odd)
                            begin
                                mirror_next = item.data[0];
                            end
                        end
                        bmsi_pkg::WIN_IRQ:
                        begin
                            if (odd)
                            begin
                                reload_next = 1'b1;
                            end
                            else
                            begin
                                latch_next = item.data;
                            end
                        end
                        default:
                        begin
                            irq_en_next = odd;
                            if (!odd)
                            begin
                                irq_level_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            bmsi_pkg::ACT_CPU_READ:
            begin
                if (item.address[15])
                begin
                    result.prg_bank   = prg_value;
                    result.prg_mapped = 1'b1;
                end
            end
            bmsi_pkg::ACT_PPU_ACC:
            begin
                if (!item.ppu_address[13])
                begin
                    result.chr_bank = chr_value & chr_mask_reg;
                end
                a12_last_next = a12;
                if (edge_seen)
                begin
                    if (low_ticks_reg > filter_reg)
                    begin
                        counter_next = counter_new;
                        reload_next  = 1'b0;
                        if (counter_new == 8'd0 && irq_en_reg)
                        begin
                            irq_level_next = 1'b1;
                        end
                    end
                    low_ticks_next = 8'd0;
                end
            end
            default:
            begin
                a12_last_next = a12;
                if (!a12 && low_ticks_reg != bmsi_pkg::LowTicksMax)
                begin
                    low_ticks_next = low_ticks_reg + 8'd1;
                end
            end
        endcase

        result.irq_line          = irq_level_next;
        result.mirror_horizontal = mirror_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                bank_regs_reg[i] <= (i == 7) ? 8'd1 : 8'd0;
            end
            bank_select_reg <= 8'd0;
            mirror_reg      <= 1'b0;
            latch_reg       <= 8'd0;
            reload_reg      <= 1'b0;
            counter_reg     <= 8'd0;
            irq_en_reg      <= 1'b0;
            irq_level_reg   <= 1'b0;
            a12_last_reg    <= 1'b0;
            low_ticks_reg   <= 8'd0;
        end
        else if (step)
        begin
            if (bank_we)
            begin
                bank_regs_reg[bank_select_reg[2:0]] <= item.data;
            end
            bank_select_reg <= bank_select_next;
            mirror_reg      <= mirror_next;
            latch_reg       <= latch_next;
            reload_reg      <= reload_next;
            counter_reg     <= counter_next;
            irq_en_reg      <= irq_en_next;
            irq_level_reg   <= irq_level_next;
            a12_last_reg    <= a12_last_next;
            low_ticks_reg   <= low_ticks_next;
        end
    end

endmodule

### hw/rtl/bmsi_out_stage.sv
// ----------------------------------------------------------------------------
// bmsi_out_stage
// result register of the result stream
// ----------------------------------------------------------------------------
module bmsi_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  bmsi_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output bmsi_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    bmsi_pkg::result_t res_reg;

    assign res_ready  = !valid_reg || out_ready;
    assign valid_next = res_ready ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### hw/rtl/bank_mapper_with_scanline_irq_top.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_top
// cartridge bank mapper with scanline interrupt counter
// ----------------------------------------------------------------------------
// Takes one bus event request per clock while the sink keeps up and returns
// one result per request: the request sits in an input register, the mapper
// logic translates it and updates its state as it moves on, and the result
// is held in an output register until the sink takes it. The
// input accepts a new request while a finished result waits, so with the
// sink ready the sustained rate is one request per cycle; a stalled sink
// backs up through the two registers. Events are cpu register writes at
// 0x8000 and above, cpu reads translated to an 8k program bank, ppu
// accesses translated to a 1k character bank that also clock the scanline
// counter on a filtered a12 edge, and cpu ticks that count a12 low time.
// Configuration registers take effect at once, so write them only while no
// request is in flight.
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] address, [23:16] data, [37:24] ppu_address, [39:38] zero
    input  logic [bmsi_pkg::InTdataW-1:0]    s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                       s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] prg_bank, [8] prg_mapped, [16:9] chr_bank, [17] irq_line,
    // [18] mirror_horizontal, [23:19] zero
    output logic [bmsi_pkg::OutTdataW-1:0]   m_axis_tdata,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [7:0]                       cfg_data
);

    bmsi_pkg::item_t   in_item;
    bmsi_pkg::item_t   item;
    bmsi_pkg::result_t res;
    bmsi_pkg::result_t out_res;
    logic              item_valid;
    logic              res_ready;
    logic              step;

    // unpack the request
    assign in_item.action      = bmsi_pkg::action_t'(s_axis_tuser);
    assign in_item.address     = s_axis_tdata[15:0];
    assign in_item.data        = s_axis_tdata[23:16];
    assign in_item.ppu_address = s_axis_tdata[37:24];

    // state advances when the registered request moves into the result register
    assign step = item_valid && res_ready;

    bmsi_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (res_ready)
    );

    bmsi_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item),
        .result    (res)
    );

    bmsi_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // pack the result, first field lowest
    assign m_axis_tdata = {5'd0, out_res.mirror_horizontal, out_res.irq_line,
                           out_res.chr_bank, out_res.prg_mapped, out_res.prg_bank};

endmodule

### hw/rtl/bmsi_checker.sv
// ----------------------------------------------------------------------------
// bmsi_checker
// port level checks of the bank mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "bank_mapper_with_scanline_irq_top_defines.svh"

module bmsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled result holds its payload
    `BMSI_ASSERT_CLK(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

    // a result without a program mapping reports zero in the program or the character bank
    `BMSI_ASSERT_CLK(a_unmapped_zero, clk, rst_n, (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[16:9] == 8'd0))

    // one result is either a program or a character translation, never both
    `BMSI_ASSERT_CLK(a_one_kind, clk, rst_n, m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[16:9] != 8'd0))

    // padding bits stay zero
    `BMSI_ASSERT_CLK(a_pad_zero, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[23:19] == 5'd0))

    // no result straight out of reset
    `BMSI_ASSERT_ANY(a_reset_empty, clk, !rst_n |=> !m_axis_tvalid)

endmodule

bind bank_mapper_with_scanline_irq_top bmsi_checker u_bmsi_checker (.*);
